// File: design/lusa_pkg.sv
// ----------------------------------------------------------------------------
// lusa_pkg
// Shared types and constants of the least-used slot assigner.
// ----------------------------------------------------------------------------
package lusa_pkg;

    localparam int KEY_W             = 16;
    localparam int CMD_W             = 2;
    localparam int SLOT_OUT_W        = 3;
    localparam int STATUS_W          = 2;
    localparam int PSIZE_W           = 4;
    localparam int PSIZE_CMP_W       = 5;
    localparam int USE_W             = 7;
    localparam int USE_MAX           = 127;
    localparam int PSIZE_RESET       = 8;
    localparam int DEF_TABLE_ENTRIES = 64;
    localparam int DEF_PALETTE_SLOTS = 8;
    localparam int APB_DATA_W        = 32;
    localparam int APB_ADDR_W        = 3;

    // Register index of the palette size register.
    localparam logic REG_PALETTE_SIZE = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_ASSIGN  = 2'd0,
        CMD_LOOKUP  = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ASSIGN,
        ST_SCAN,
        ST_SHIFT,
        ST_RESP
    } state_t;

    // Update request for the use count bank.
    typedef struct packed {
        logic clear;
        logic inc;
        logic dec;
    } use_ctl_t;

endpackage

// File: design/lusa_ram.sv
// ----------------------------------------------------------------------------
// lusa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lusa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/lusa_use_cnt.sv
// ----------------------------------------------------------------------------
// lusa_use_cnt
// Per-slot use counters with saturating increment, clamped decrement and
// a clear of the whole bank at once.
// ----------------------------------------------------------------------------
module lusa_use_cnt import lusa_pkg::*; #(
    parameter int PALETTE_SLOTS = DEF_PALETTE_SLOTS,
    localparam int SLOT_W = (PALETTE_SLOTS > 1) ? $clog2(PALETTE_SLOTS) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  use_ctl_t          ctl,
    input  logic [SLOT_W-1:0] upd_idx,
    input  logic [SLOT_W-1:0] rd_idx,
    output logic [USE_W-1:0]  rd_cnt
);

    logic [USE_W-1:0] cnt_reg  [PALETTE_SLOTS];
    logic [USE_W-1:0] cnt_next [PALETTE_SLOTS];

    always_comb begin
        cnt_next = cnt_reg;
        if (ctl.clear) begin
            for (int i = 0; i < PALETTE_SLOTS; i++) begin
                cnt_next[i] = '0;
            end
        end else if (ctl.inc) begin
            if (cnt_reg[upd_idx] != USE_W'(USE_MAX)) begin
                cnt_next[upd_idx] = cnt_reg[upd_idx] + USE_W'(1);
            end
        end else if (ctl.dec) begin
            if (cnt_reg[upd_idx] != '0) begin
                cnt_next[upd_idx] = cnt_reg[upd_idx] - USE_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PALETTE_SLOTS; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Indexes past the last slot only occur once the search has ended.
    assign rd_cnt = (32'(rd_idx) < PALETTE_SLOTS) ? cnt_reg[rd_idx] : '0;

endmodule

// File: design/least_used_slot_assigner.sv
// ----------------------------------------------------------------------------
// least_used_slot_assigner
// Assigns palette slots by least use and keeps a key-to-slot table.
// ----------------------------------------------------------------------------
// The block takes one item at a time and returns one result item for each.
// Clear-all, a refused assign, and a lookup or release on an empty table go
// straight to the result. The slot search of an assign reads one use
// counter per cycle and stops early at a counter of zero. Lookup and release
// scan the table from index 0 up to a hit or the fill count; a release hit
// is followed by a move-down pass from the entry after the hit. Lookup and
// release are bound by the single read port of the table memory, which is
// scanned one entry per cycle. While an earlier result still waits in the
// output register, the new result is held back until that one is taken. The
// input is ready again as soon as the result sits in the output register,
// even if the downstream side has not taken it yet. The table memory needs
// no clearing pass after reset: only entries below the fill count are ever
// read. The palette size register lies at byte address 0 of the APB port.
// Its value is clamped to 1..PALETTE_SLOTS when used, and it should only be
// written while the block is idle.
// ----------------------------------------------------------------------------
module least_used_slot_assigner import lusa_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int PALETTE_SLOTS = DEF_PALETTE_SLOTS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Command channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CMD_W-1:0]      s_cmd,
    input  logic [KEY_W-1:0]      s_key,
    // Result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SLOT_OUT_W-1:0] m_slot,
    output logic [STATUS_W-1:0]   m_status
);

    localparam int SLOT_W  = (PALETTE_SLOTS > 1) ? $clog2(PALETTE_SLOTS) : 1;
    localparam int AW      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW      = $clog2(TABLE_ENTRIES + 1);
    localparam int ENTRY_W = KEY_W + SLOT_W;

    // ------------------------------------------------------------------------
    // Configuration register. Only the register index bit is decoded; the
    // byte offset within the word is ignored.
    // ------------------------------------------------------------------------
    logic [PSIZE_W-1:0] palette_size_reg;
    logic               cfg_hit;
    logic               cfg_write;

    assign cfg_hit   = (paddr[APB_ADDR_W-1:2] == REG_PALETTE_SIZE);
    assign cfg_write = psel && penable && pwrite && cfg_hit;
    assign pready    = 1'b1;
    assign prdata    = cfg_hit ? APB_DATA_W'(palette_size_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            palette_size_reg <= PSIZE_W'(PSIZE_RESET);
        end else if (cfg_write) begin
            palette_size_reg <= pwdata[PSIZE_W-1:0];
        end
    end

    // Number of slots the search may choose from, clamped to 1..PALETTE_SLOTS.
    logic [PSIZE_CMP_W-1:0] palette_n;

    always_comb begin
        if (palette_size_reg == '0) begin
            palette_n = PSIZE_CMP_W'(1);
        end else if (PSIZE_CMP_W'(palette_size_reg) > PSIZE_CMP_W'(PALETTE_SLOTS)) begin
            palette_n = PSIZE_CMP_W'(PALETTE_SLOTS);
        end else begin
            palette_n = PSIZE_CMP_W'(palette_size_reg);
        end
    end

    // ------------------------------------------------------------------------
    // Control and datapath registers.
    // ------------------------------------------------------------------------
    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [CW-1:0]          entry_count_reg, entry_count_next;
    logic [CW-1:0]          scan_idx_reg, scan_idx_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic [CW-1:0]          cmp_idx_reg, cmp_idx_next;
    logic [PSIZE_CMP_W-1:0] uidx_reg, uidx_next;
    logic [SLOT_W-1:0]      best_reg, best_next;
    logic [USE_W-1:0]       best_cnt_reg, best_cnt_next;
    logic [SLOT_W-1:0]      res_slot_reg, res_slot_next;
    status_t                res_status_reg, res_status_next;
    logic                   m_valid_reg, m_valid_next;
    logic [SLOT_OUT_W-1:0]  m_slot_reg, m_slot_next;
    status_t                m_status_reg, m_status_next;

    // Table memory and use counter interface.
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ENTRY_W-1:0] mem_rdata;
    logic [KEY_W-1:0]   rd_key;
    logic [SLOT_W-1:0]  rd_slot;
    logic [CW-1:0]      shift_waddr;
    logic               issue;

    use_ctl_t           use_ctl;
    logic [SLOT_W-1:0]  use_upd_idx;
    logic [SLOT_W-1:0]  use_rd_idx;
    logic [USE_W-1:0]   use_rd_cnt;

    assign rd_key      = mem_rdata[ENTRY_W-1:SLOT_W];
    assign rd_slot     = mem_rdata[SLOT_W-1:0];
    assign shift_waddr = cmp_idx_reg - CW'(1);
    // A new table read is started while the scan index is below the fill.
    assign issue       = (scan_idx_reg < entry_count_reg);

    lusa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (scan_idx_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    lusa_use_cnt #(
        .PALETTE_SLOTS (PALETTE_SLOTS)
    ) u_use_cnt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (use_ctl),
        .upd_idx (use_upd_idx),
        .rd_idx  (use_rd_idx),
        .rd_cnt  (use_rd_cnt)
    );

    // ------------------------------------------------------------------------
    // Command sequencer.
    // Assign walks the use counters; lookup and release stream the table one
    // entry per cycle with the compare in the cycle after the read; release
    // then moves the later entries down, reading entry i+1 and writing entry i
    // in the following cycle, so no read ever sees a stale slot.
    // ------------------------------------------------------------------------
    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        entry_count_next = entry_count_reg;
        scan_idx_next    = scan_idx_reg;
        cmp_valid_next   = cmp_valid_reg;
        cmp_idx_next     = cmp_idx_reg;
        uidx_next        = uidx_reg;
        best_next        = best_reg;
        best_cnt_next    = best_cnt_reg;
        res_slot_next    = res_slot_reg;
        res_status_next  = res_status_reg;
        m_valid_next     = m_valid_reg;
        m_slot_next      = m_slot_reg;
        m_status_next    = m_status_reg;

        mem_we      = 1'b0;
        mem_waddr   = entry_count_reg[AW-1:0];
        mem_wdata   = {key_reg, best_reg};
        use_ctl     = '0;
        use_upd_idx = best_reg;
        use_rd_idx  = (state_reg == ST_ASSIGN) ? uidx_reg[SLOT_W-1:0] : '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next = cmd_t'(s_cmd);
                    key_next = s_key;
                    res_slot_next   = '0;
                    res_status_next = STATUS_OK;
                    case (cmd_t'(s_cmd))
                        CMD_ASSIGN: begin
                            if (entry_count_reg == CW'(TABLE_ENTRIES)) begin
                                res_status_next = STATUS_FULL;
                                state_next      = ST_RESP;
                            end else begin
                                uidx_next     = PSIZE_CMP_W'(1);
                                best_next     = '0;
                                best_cnt_next = use_rd_cnt;
                                state_next    = ST_ASSIGN;
                            end
                        end
                        CMD_LOOKUP, CMD_RELEASE: begin
                            if (entry_count_reg == '0) begin
                                res_status_next = STATUS_NOT_FOUND;
                                state_next      = ST_RESP;
                            end else begin
                                scan_idx_next  = '0;
                                cmp_valid_next = 1'b0;
                                state_next     = ST_SCAN;
                            end
                        end
                        CMD_CLEAR: begin
                            entry_count_next = '0;
                            use_ctl.clear    = 1'b1;
                            state_next       = ST_RESP;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_ASSIGN: begin
                if (uidx_reg >= palette_n || best_cnt_reg == '0) begin
                    use_ctl.inc      = 1'b1;
                    mem_we           = 1'b1;
                    entry_count_next = entry_count_reg + CW'(1);
                    res_slot_next    = best_reg;
                    res_status_next  = STATUS_OK;
                    state_next       = ST_RESP;
                end else begin
                    if (use_rd_cnt < best_cnt_reg) begin
                        best_next     = uidx_reg[SLOT_W-1:0];
                        best_cnt_next = use_rd_cnt;
                    end
                    uidx_next = uidx_reg + PSIZE_CMP_W'(1);
                end
            end

            ST_SCAN: begin
                cmp_valid_next = issue;
                cmp_idx_next   = scan_idx_reg;
                if (issue) begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                if (cmp_valid_reg && rd_key == key_reg) begin
                    res_slot_next   = rd_slot;
                    res_status_next = STATUS_OK;
                    if (cmd_reg == CMD_LOOKUP) begin
                        state_next = ST_RESP;
                    end else begin
                        // Start moving entries down from the one after the hit.
                        scan_idx_next  = cmp_idx_reg + CW'(1);
                        cmp_valid_next = 1'b0;
                        state_next     = ST_SHIFT;
                    end
                end else if (!cmp_valid_reg && !issue) begin
                    res_slot_next   = '0;
                    res_status_next = STATUS_NOT_FOUND;
                    state_next      = ST_RESP;
                end
            end

            ST_SHIFT: begin
                cmp_valid_next = issue;
                cmp_idx_next   = scan_idx_reg;
                if (issue) begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                if (cmp_valid_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = shift_waddr[AW-1:0];
                    mem_wdata = mem_rdata;
                end else if (!issue) begin
                    use_ctl.dec      = 1'b1;
                    use_upd_idx      = res_slot_reg;
                    entry_count_next = entry_count_reg - CW'(1);
                    state_next       = ST_RESP;
                end
            end

            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_slot_next   = SLOT_OUT_W'(res_slot_reg);
                    m_status_next = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            cmp_valid_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            cmp_valid_reg   <= cmp_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        uidx_reg       <= uidx_next;
        best_reg       <= best_next;
        best_cnt_reg   <= best_cnt_next;
        res_slot_reg   <= res_slot_next;
        res_status_reg <= res_status_next;
        m_slot_reg     <= m_slot_next;
        m_status_reg   <= m_status_next;
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_slot   = m_slot_reg;
    assign m_status = m_status_reg;

`ifndef SYNTH
    // The fill count never runs past the table depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_count_reg <= CW'(TABLE_ENTRIES))
        else $error("entry count exceeds table depth");

    // A completed assign appends exactly one entry.
    a_assign_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ASSIGN && state_next == ST_RESP)
        |=> entry_count_reg == $past(entry_count_reg) + CW'(1))
        else $error("assign did not append one entry");

    // Clear-all empties the table.
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_cmd == CMD_CLEAR) |=> entry_count_reg == '0)
        else $error("clear-all left entries in the table");

    // A shift write never targets below the start of the table.
    a_shift_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT && cmp_valid_reg) |-> cmp_idx_reg != '0)
        else $error("shift write address underflow");

    // Refused or missed commands report slot zero.
    a_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STATUS_OK) |-> m_slot == '0)
        else $error("nonzero slot on a failed command");
`endif

endmodule
